### hw/rtl/dss_pkg.sv
// ============================================================================
// dss_pkg
// Shared types, codes and constant tables of the drum step sequencer layer.
// ============================================================================
package dss_pkg;

  // Number of pattern steps in one bar.
  localparam int STEPS = 16;

  // Width of a pattern step position.
  localparam int StepIdxW = (STEPS > 1) ? $clog2(STEPS) : 1;

  // Number of sub-beat divisions in one beat.
  localparam int DivCount = 24;

  // Velocity and gain values are seven bits wide.
  localparam int VelW  = 7;
  localparam int NoteW = 7;

  // Index width of the configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_OUTPUT_MODE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_NOTE_NUMBER     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BASE_VELOCITY   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_HUMANIZE_CHANCE = 2'd3;

  // Step kinds. Codes 6 and 7 are stored but act as an empty mask.
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_SINGLE = 3'd1;
  localparam logic [2:0] KIND_DOUBLE = 3'd2;
  localparam logic [2:0] KIND_TRIPLE = 3'd3;
  localparam logic [2:0] KIND_QUAD   = 3'd4;
  localparam logic [2:0] KIND_HOLD   = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [NoteW-1:0] NoteReset = 7'd36;
  localparam logic [VelW-1:0]  VelReset  = 7'd32;

  // Sample slots cover the notes starting at this one.
  localparam logic [NoteW-1:0] SampleBaseNote = 7'd36;
  localparam logic [NoteW-1:0] SampleEndNote  = 7'd44;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_BEAT  = 2'd1,
    ACT_DIV   = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_NOTE_OFF = 2'd1,
    EV_NOTE_ON  = 2'd2,
    EV_SAMPLE   = 2'd3
  } event_e;

  // Random draws that come with a division tick.
  typedef struct packed {
    logic [6:0] percent;
    logic [3:0] tenth;
    logic       sign;
  } humanize_t;

  // Velocities offered to the result logic.
  typedef struct packed {
    logic [VelW-1:0] beat_vel;
    logic [VelW-1:0] div_vel;
  } vel_t;

  // Division mask loaded on a beat for each step kind.
  function automatic logic [DivCount-1:0] kind_mask(input logic [2:0] kind);
    logic [DivCount-1:0] m;
    case (kind)
      KIND_SINGLE: m = 24'h000001;
      KIND_DOUBLE: m = 24'h001001;
      KIND_TRIPLE: m = 24'h010101;
      KIND_QUAD:   m = 24'h041041;
      KIND_HOLD:   m = 24'h111111;
      default:     m = 24'h000000;
    endcase
    return m;
  endfunction

  // Humanize offset: 25 plus tenth*25/9, truncated, for every 4-bit draw.
  function automatic logic [6:0] human_offset(input logic [3:0] tenth);
    logic [6:0] o;
    case (tenth)
      4'd0:    o = 7'd25;
      4'd1:    o = 7'd27;
      4'd2:    o = 7'd30;
      4'd3:    o = 7'd33;
      4'd4:    o = 7'd36;
      4'd5:    o = 7'd38;
      4'd6:    o = 7'd41;
      4'd7:    o = 7'd44;
      4'd8:    o = 7'd47;
      4'd9:    o = 7'd50;
      4'd10:   o = 7'd52;
      4'd11:   o = 7'd55;
      4'd12:   o = 7'd58;
      4'd13:   o = 7'd61;
      4'd14:   o = 7'd63;
      default: o = 7'd66;
    endcase
    return o;
  endfunction

endpackage

### hw/rtl/dss_velocity.sv
// ============================================================================
// dss_velocity
// Beat velocity and humanized division velocity of one drum layer.
// ============================================================================
module dss_velocity
  import dss_pkg::*;
(
  input  logic [VelW-1:0] base_velocity_i,
  input  logic [6:0]      humanize_chance_i,
  input  humanize_t       draw_i,
  output vel_t            vel_o
);

  logic [6:0] offset;
  logic [7:0] sum;
  logic [7:0] diff;
  logic [VelW-1:0] div_vel;

  // The offset only applies when the draw falls under the chance.
  assign offset = (humanize_chance_i > draw_i.percent) ? human_offset(draw_i.tenth) : 7'd0;
  assign sum    = {1'b0, base_velocity_i} + {1'b0, offset};
  assign diff   = {1'b0, base_velocity_i} - {1'b0, offset};

  always_comb begin
    if (draw_i.sign) begin
      div_vel = (offset > base_velocity_i) ? '0 : diff[VelW-1:0];
    end else begin
      div_vel = sum[VelW] ? {VelW{1'b1}} : sum[VelW-1:0];
    end
  end

  assign vel_o.div_vel  = div_vel;
  assign vel_o.beat_vel = (base_velocity_i == '0) ? VelW'(1) : base_velocity_i;

endmodule

### hw/rtl/drum_step_sequencer_ratchet.sv
// ============================================================================
// drum_step_sequencer_ratchet
// One drum layer of a step sequencer with ratchet divisions per step.
// ============================================================================
//
//  Channel  | Direction | Handshake              | Word
//  ---------+-----------+------------------------+------------------------------
//  in       | input     | in_valid_i / in_stall_o | action and its operands
//  out      | output    | out_valid_o / out_stall_i | event, note, velocity, slot
//  cfg      | input     | cfg_valid_i / cfg_ready_o | register index and data
//
// Every accepted input word produces exactly one output word. The work is
// done in the cycle of acceptance: the pattern, beat position and division
// mask update at that edge and the result lands in the output register, or
// in the skid register behind it, which absorbs one extra word while the
// output is stalled. A word is accepted every cycle unless the input stalls,
// which it does only while that skid register is full.
// Reset clears the pattern to empty steps, the beat position and the mask,
// and loads the configuration registers with their defaults.
// The configuration port is always ready; it is to be written only when idle, which the block itself does not enforce.
// ============================================================================
module drum_step_sequencer_ratchet
  import dss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          action_i,
  input  logic [3:0]          step_index_i,
  input  logic [2:0]          step_kind_i,
  input  logic [4:0]          division_index_i,
  input  logic [6:0]          random_percent_i,
  input  logic [3:0]          random_tenth_i,
  input  logic                random_sign_i,
  // Output channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          event_res_o,
  output logic [NoteW-1:0]    note_o,
  output logic [VelW-1:0]     velocity_o,
  output logic [2:0]          sample_slot_o,
  // Configuration channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef struct packed {
    event_e            ev;
    logic [NoteW-1:0]  note;
    logic [VelW-1:0]   velocity;
    logic [2:0]        slot;
  } result_t;

  // Configuration registers.
  logic             output_mode_q;
  logic [NoteW-1:0] note_number_q;
  logic [VelW-1:0]  base_velocity_q;
  logic [6:0]       humanize_chance_q;

  // Sequencer state.
  logic [2:0]          pattern_q [STEPS];
  logic [2:0]          pattern_d [STEPS];
  logic [StepIdxW-1:0] beat_pos_q, beat_pos_d;
  logic [DivCount-1:0] div_mask_q, div_mask_d;

  // Output register and skid register.
  result_t main_q, main_d;
  logic    main_valid_q, main_valid_d;
  result_t skid_q, skid_d;
  logic    skid_valid_q, skid_valid_d;

  logic      in_accept;
  logic      out_pop;
  action_e   action;
  humanize_t draw;
  vel_t      vel;
  result_t   res;
  logic [2:0]          cur_kind;
  logic [DivCount-1:0] cur_mask;
  logic [31:0]         mask_wide;
  logic                div_hit;
  logic                slot_ok;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i && !skid_valid_q;
  assign out_pop     = main_valid_q && !out_stall_i;
  assign action      = action_e'(action_i);

  assign draw.percent = random_percent_i;
  assign draw.tenth   = random_tenth_i;
  assign draw.sign    = random_sign_i;

  dss_velocity u_velocity (
    .base_velocity_i   (base_velocity_q),
    .humanize_chance_i (humanize_chance_q),
    .draw_i            (draw),
    .vel_o             (vel)
  );

  // Step under the beat pointer and the mask it selects.
  assign cur_kind  = pattern_q[beat_pos_q];
  assign cur_mask  = kind_mask(cur_kind);
  assign mask_wide = {{(32 - DivCount){1'b0}}, div_mask_q} >> division_index_i;
  assign div_hit   = (32'(division_index_i) < DivCount) && mask_wide[0];
  assign slot_ok   = (note_number_q >= SampleBaseNote) && (note_number_q < SampleEndNote);

  // Result and next state for the word at the input.
  always_comb begin
    res        = '{ev: EV_NONE, note: '0, velocity: '0, slot: '0};
    pattern_d  = pattern_q;
    beat_pos_d = beat_pos_q;
    div_mask_d = div_mask_q;

    case (action)
      ACT_WRITE: begin
        if (32'(step_index_i) < STEPS) begin
          pattern_d[StepIdxW'(step_index_i)] = step_kind_i;
        end
      end
      ACT_BEAT: begin
        div_mask_d = cur_mask;
        if (cur_kind != KIND_NONE) begin
          // In note mode the first division plays right on the beat.
          if (cur_mask[0] && !output_mode_q) begin
            res = '{ev: EV_NOTE_ON, note: note_number_q, velocity: vel.beat_vel, slot: '0};
            div_mask_d[0] = 1'b0;
          end
        end else if (!output_mode_q) begin
          res = '{ev: EV_NOTE_OFF, note: note_number_q, velocity: '0, slot: '0};
        end
        beat_pos_d = (32'(beat_pos_q) == STEPS - 1) ? '0 : beat_pos_q + 1'b1;
      end
      ACT_DIV: begin
        if (div_hit) begin
          if (!output_mode_q) begin
            res = '{ev: EV_NOTE_ON, note: note_number_q, velocity: vel.div_vel, slot: '0};
          end else if (slot_ok) begin
            res = '{ev: EV_SAMPLE, note: note_number_q, velocity: vel.div_vel,
                    slot: 3'(note_number_q - SampleBaseNote)};
          end
        end
      end
      default: begin
        for (int i = 0; i < STEPS; i++) begin
          pattern_d[i] = KIND_NONE;
        end
        div_mask_d = '0;
        beat_pos_d = '0;
      end
    endcase
  end

  // Output register with one skid entry behind it.
  always_comb begin
    main_d       = main_q;
    main_valid_d = main_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (out_pop || !main_valid_q) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = res;
        main_valid_d = in_accept;
      end
    end else if (in_accept) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
      beat_pos_q   <= '0;
      div_mask_q   <= '0;
      for (int i = 0; i < STEPS; i++) begin
        pattern_q[i] <= KIND_NONE;
      end
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
      if (in_accept) begin
        beat_pos_q <= beat_pos_d;
        div_mask_q <= div_mask_d;
        pattern_q  <= pattern_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_mode_q     <= 1'b0;
      note_number_q     <= NoteReset;
      base_velocity_q   <= VelReset;
      humanize_chance_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_OUTPUT_MODE:     output_mode_q     <= cfg_data_i[0];
        CFG_NOTE_NUMBER:     note_number_q     <= cfg_data_i;
        CFG_BASE_VELOCITY:   base_velocity_q   <= cfg_data_i;
        CFG_HUMANIZE_CHANCE: humanize_chance_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o   = main_valid_q;
  assign event_res_o   = main_q.ev;
  assign note_o        = main_q.note;
  assign velocity_o    = main_q.velocity;
  assign sample_slot_o = main_q.slot;

endmodule

### hw/rtl/dss_checker.sv
// ============================================================================
// dss_checker
// Port-level checks of the drum step sequencer layer, bound to the top level.
// ============================================================================
module dss_checker
  import dss_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [1:0]       event_res_o,
  input logic [NoteW-1:0] note_o,
  input logic [VelW-1:0]  velocity_o,
  input logic [2:0]       sample_slot_o
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // The input only stalls while results are waiting at the output.
  a_stall_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending output");

  // An empty event carries all-zero fields.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EV_NONE |->
      note_o == '0 && velocity_o == '0 && sample_slot_o == '0)
    else $error("empty event with nonzero fields");

  // Only a sample trigger carries a slot, and a note-off has no velocity.
  a_slot_only_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_NOTE_OFF || event_res_o == EV_NOTE_ON) |->
      sample_slot_o == '0 && (event_res_o == EV_NOTE_ON || velocity_o == '0))
    else $error("note event with slot or note-off with velocity");

endmodule

bind drum_step_sequencer_ratchet dss_checker u_dss_checker (.*);

### sim/drum_step_sequencer_ratchet_tb.sv
// ============================================================================
// drum_step_sequencer_ratchet_tb
// Self-checking bench for one drum layer of the ratchet step sequencer.
// A driver offers words from a pending queue, and a behavioral model of the
// layer predicts one event word for every accepted input word. A monitor
// compares each output word, field by field, with the oldest prediction.
// The run walks through directed corner cases and then through randomized
// phases under several register settings, with random stalls on both sides.
// ============================================================================
module drum_step_sequencer_ratchet_tb
  import dss_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One input word as it is offered to the block.
  typedef struct {
    action_e    action;
    logic [3:0] step_index;
    logic [2:0] step_kind;
    logic [4:0] division_index;
    logic [6:0] random_percent;
    logic [3:0] random_tenth;
    logic       random_sign;
  } step_word_t;

  // One output word: the event the layer sends for an input word.
  typedef struct {
    event_e          kind;
    logic [NoteW-1:0] note;
    logic [VelW-1:0]  velocity;
    logic [2:0]       slot;
  } layer_event_t;

  // Clock, reset and every block input start at known values.
  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic [1:0]          action_i         = '0;
  logic [3:0]          step_index_i     = '0;
  logic [2:0]          step_kind_i      = '0;
  logic [4:0]          division_index_i = '0;
  logic [6:0]          random_percent_i = '0;
  logic [3:0]          random_tenth_i   = '0;
  logic                random_sign_i    = 1'b0;
  logic                out_stall_i      = 1'b0;
  logic                cfg_valid_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i      = '0;
  logic [CfgDataW-1:0] cfg_data_i       = '0;

  logic                in_stall_o;
  logic                out_valid_o;
  logic [1:0]          event_res_o;
  logic [NoteW-1:0]    note_o;
  logic [VelW-1:0]     velocity_o;
  logic [2:0]          sample_slot_o;
  logic                cfg_ready_o;

  drum_step_sequencer_ratchet dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .step_index_i     (step_index_i),
    .step_kind_i      (step_kind_i),
    .division_index_i (division_index_i),
    .random_percent_i (random_percent_i),
    .random_tenth_i   (random_tenth_i),
    .random_sign_i    (random_sign_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_res_o      (event_res_o),
    .note_o           (note_o),
    .velocity_o       (velocity_o),
    .sample_slot_o    (sample_slot_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Words waiting to be offered, and events predicted but not yet seen.
  step_word_t   stimulus_words[$];
  layer_event_t expected_events[$];

  // Model copy of the layer registers.
  logic             cfg_mode     = 1'b0;
  logic [NoteW-1:0] cfg_note     = 7'd36;
  logic [VelW-1:0]  cfg_velocity = 7'd32;
  logic [6:0]       cfg_chance   = 7'd0;

  // Model copy of the layer state: pattern, beat position, division mask.
  logic [2:0]          steps_q [STEPS];
  int                  beat_pos = 0;
  logic [DivCount-1:0] ratchet_mask = '0;

  int   fail_count = 0;
  logic idle_on    = 1'b1;   // random idle bursts allowed on both sides
  logic hold_go    = 1'b0;   // starts the long receiver hold-off
  logic rx_hold    = 1'b0;
  int   tx_gap     = 0;
  int   rx_gap     = 0;

  step_word_t   offered;
  layer_event_t predicted;
  layer_event_t want;

  initial begin
    for (int i = 0; i < STEPS; i++) steps_q[i] = KIND_NONE;
  end

  // --------------------------------------------------------------------------
  // Clock and reset. Reset is held low only at the start of the run.
  // --------------------------------------------------------------------------
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard limit on the run time, far above the slowest correct run.
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Layer model.
  // --------------------------------------------------------------------------

  // Division bits a step kind arms on a beat. Kinds 6 and 7 arm nothing.
  function automatic logic [DivCount-1:0] ratchet_bits(input logic [2:0] kind);
    case (kind)
      KIND_SINGLE: return 24'h000001;
      KIND_DOUBLE: return 24'h001001;
      KIND_TRIPLE: return 24'h010101;
      KIND_QUAD:   return 24'h041041;
      KIND_HOLD:   return 24'h111111;
      default:     return 24'h000000;
    endcase
  endfunction

  // Applies one accepted word to the model state and works out its event.
  task automatic play_word(input step_word_t w, output layer_event_t ev);
    int          vel;
    int          offset;
    logic [2:0]  kind;
    ev.kind     = EV_NONE;
    ev.note     = '0;
    ev.velocity = '0;
    ev.slot     = '0;
    case (w.action)
      ACT_WRITE: begin
        if (int'(w.step_index) < STEPS) steps_q[w.step_index] = w.step_kind;
      end
      ACT_BEAT: begin
        kind = steps_q[beat_pos];
        ratchet_mask = ratchet_bits(kind);
        if (kind != KIND_NONE) begin
          // In note mode division 0 sounds right on the beat and is used up;
          // in sample mode it stays armed for division tick 0.
          if (ratchet_mask[0] && !cfg_mode) begin
            vel = cfg_velocity;
            if (vel < 1) vel = 1;
            ev.kind     = EV_NOTE_ON;
            ev.note     = cfg_note;
            ev.velocity = vel[6:0];
            ratchet_mask[0] = 1'b0;
          end
        end else if (!cfg_mode) begin
          ev.kind = EV_NOTE_OFF;
          ev.note = cfg_note;
        end
        beat_pos = (beat_pos + 1) % STEPS;
      end
      ACT_DIV: begin
        if (int'(w.division_index) < DivCount) begin
          if (ratchet_mask[w.division_index]) begin
            offset = 0;
            if (cfg_chance > w.random_percent)
              offset = 25 + (int'(w.random_tenth) * 25) / 9;
            if (w.random_sign) offset = -offset;
            vel = int'(cfg_velocity) + offset;
            if (vel < 0) vel = 0;
            if (vel > 127) vel = 127;
            if (!cfg_mode) begin
              ev.kind     = EV_NOTE_ON;
              ev.note     = cfg_note;
              ev.velocity = vel[6:0];
            end else if (cfg_note >= 7'd36 && cfg_note < 7'd44) begin
              ev.kind     = EV_SAMPLE;
              ev.note     = cfg_note;
              ev.velocity = vel[6:0];
              ev.slot     = 3'(cfg_note - 7'd36);
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < STEPS; i++) steps_q[i] = KIND_NONE;
        ratchet_mask = '0;
        beat_pos = 0;
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver. The current word is predicted at the edge where it is accepted,
  // and the next one is fetched from the queue, possibly after an idle burst.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        play_word(offered, predicted);
        expected_events.push_back(predicted);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (stimulus_words.size() != 0) begin
          offered = stimulus_words.pop_front();
          action_i         <= offered.action;
          step_index_i     <= offered.step_index;
          step_kind_i      <= offered.step_kind;
          division_index_i <= offered.division_index;
          random_percent_i <= offered.random_percent;
          random_tenth_i   <= offered.random_tenth;
          random_sign_i    <= offered.random_sign;
          in_valid_i       <= 1'b1;
          if (idle_on && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 11);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: short random bursts, plus the long hold-off when asked.
  always @(posedge clk_i) begin
    if (rx_gap > 0) rx_gap--;
    else if (idle_on && $urandom_range(0, 6) == 0) rx_gap = $urandom_range(1, 11);
    out_stall_i <= rx_hold || (rx_gap > 0);
  end

  // The long hold-off is counted here, apart from the stimulus flow, so the
  // sender keeps offering while the output is held and the input backs up.
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor. Every accepted output word is checked against the oldest
  // prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_events.size() == 0) begin
        $error("output word with nothing expected: event_res %0d note %0d",
               event_res_o, note_o);
        fail_count++;
      end else begin
        want = expected_events.pop_front();
        if (event_res_o !== want.kind) begin
          $error("event_res: expected %0d, actual %0d", want.kind, event_res_o);
          fail_count++;
        end
        if (note_o !== want.note) begin
          $error("note: expected %0d, actual %0d", want.note, note_o);
          fail_count++;
        end
        if (velocity_o !== want.velocity) begin
          $error("velocity: expected %0d, actual %0d", want.velocity, velocity_o);
          fail_count++;
        end
        if (sample_slot_o !== want.slot) begin
          $error("sample_slot: expected %0d, actual %0d", want.slot, sample_slot_o);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // A word with every field random over its full width.
  function automatic step_word_t noise_word();
    step_word_t w;
    w.action         = action_e'($urandom_range(0, 3));
    w.step_index     = 4'($urandom);
    w.step_kind      = 3'($urandom);
    w.division_index = 5'($urandom);
    w.random_percent = 7'($urandom);
    w.random_tenth   = 4'($urandom);
    w.random_sign    = 1'($urandom);
    return w;
  endfunction

  // A random word shaped so that written steps get played: mostly division
  // ticks that land on armed ratchet positions, some writes and beats, and
  // the odd clear.
  function automatic step_word_t random_word();
    step_word_t w;
    int         pick;
    w = noise_word();
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      w.action = ACT_WRITE;
      if ($urandom_range(0, 9) < 8) w.step_kind = 3'($urandom_range(1, 5));
    end else if (pick < 40) begin
      w.action = ACT_BEAT;
    end else if (pick < 97) begin
      w.action = ACT_DIV;
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 2))
          0:       w.division_index = 5'(4 * $urandom_range(0, 5));
          1:       w.division_index = 5'(6 * $urandom_range(0, 3));
          default: w.division_index = 5'(8 * $urandom_range(0, 2));
        endcase
      end
    end else begin
      w.action = ACT_CLEAR;
    end
    return w;
  endfunction

  // Queues a write, beat or clear; unused fields carry random noise.
  task automatic queue_step(input action_e act, input int step, input int kind);
    step_word_t w;
    w = noise_word();
    w.action = act;
    if (act == ACT_WRITE) begin
      w.step_index = 4'(step);
      w.step_kind  = 3'(kind);
    end
    stimulus_words.push_back(w);
  endtask

  // Queues a division tick with the given random draws.
  task automatic queue_div(input int idx, input int pct, input int tenth, input bit sgn);
    step_word_t w;
    w = noise_word();
    w.action         = ACT_DIV;
    w.division_index = 5'(idx);
    w.random_percent = 7'(pct);
    w.random_tenth   = 4'(tenth);
    w.random_sign    = sgn;
    stimulus_words.push_back(w);
  endtask

  // Waits until every queued word is taken and every prediction is matched.
  task automatic wait_until_quiet();
    @(negedge clk_i);
    while (stimulus_words.size() != 0 || in_valid_i || expected_events.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes one register over the configuration channel and mirrors it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_OUTPUT_MODE:     cfg_mode     = data[0];
      CFG_NOTE_NUMBER:     cfg_note     = data;
      CFG_BASE_VELOCITY:   cfg_velocity = data;
      default:             cfg_chance   = data;
    endcase
  endtask

  // Sets the whole layer. The mode register only keeps bit 0, so the upper
  // bits of its data are filled with noise.
  task automatic set_layer(input bit mode, input int note, input int vel, input int chance);
    write_reg(CFG_OUTPUT_MODE, {6'($urandom), mode});
    write_reg(CFG_NOTE_NUMBER, 7'(note));
    write_reg(CFG_BASE_VELOCITY, 7'(vel));
    write_reg(CFG_HUMANIZE_CHANCE, 7'(chance));
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    wait (rst_ni);

    // Reset settings, note mode: empty step note-off, ratchet kinds, the
    // unknown kinds, a division that repeats, indexes past the last
    // division, and a clear.
    @(negedge clk_i);
    queue_step(ACT_BEAT, 0, 0);
    queue_step(ACT_WRITE, 1, KIND_QUAD);
    queue_step(ACT_WRITE, 2, KIND_HOLD);
    queue_step(ACT_WRITE, 3, 6);
    queue_step(ACT_WRITE, 4, 7);
    queue_step(ACT_WRITE, 15, KIND_TRIPLE);
    queue_step(ACT_BEAT, 0, 0);
    queue_div(0, 0, 0, 0);
    queue_div(6, 0, 9, 1);
    queue_div(18, 99, 15, 0);
    queue_div(18, 127, 0, 1);
    queue_step(ACT_BEAT, 0, 0);
    queue_div(20, 0, 3, 0);
    queue_div(24, 0, 0, 0);
    queue_div(31, 0, 0, 0);
    queue_step(ACT_BEAT, 0, 0);
    queue_step(ACT_BEAT, 0, 0);
    queue_div(4, 0, 0, 0);
    queue_step(ACT_CLEAR, 0, 0);
    queue_step(ACT_BEAT, 0, 0);
    wait_until_quiet();

    // Sample mode on the top slot with full humanize: division 0 survives
    // the beat, and the clamp is hit from above.
    set_layer(1, 43, 127, 100);
    @(negedge clk_i);
    queue_step(ACT_CLEAR, 0, 0);
    queue_step(ACT_WRITE, 0, KIND_TRIPLE);
    queue_step(ACT_WRITE, 1, KIND_HOLD);
    queue_step(ACT_BEAT, 0, 0);
    queue_div(0, 99, 15, 0);
    queue_div(8, 0, 15, 1);
    queue_div(16, 100, 7, 1);
    queue_step(ACT_BEAT, 0, 0);
    queue_div(4, 5, 9, 1);
    wait_until_quiet();

    // Zero velocity in note mode: the beat clamps up to 1 and a negative
    // offset clamps down to 0.
    set_layer(0, 127, 0, 127);
    @(negedge clk_i);
    queue_step(ACT_CLEAR, 0, 0);
    queue_step(ACT_WRITE, 0, KIND_SINGLE);
    queue_step(ACT_WRITE, 1, KIND_DOUBLE);
    queue_step(ACT_BEAT, 0, 0);
    queue_step(ACT_BEAT, 0, 0);
    queue_div(12, 0, 0, 1);
    queue_div(12, 126, 15, 0);
    queue_div(0, 0, 0, 0);
    wait_until_quiet();

    // Random phases, each under its own settings and each drained before
    // the registers change. The last phase runs with no idling.
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: set_layer(0, 36, 32, 0);
        1: set_layer(1, 36, 64, 50);
        2: set_layer(0, 127, 127, 100);
        3: set_layer(1, 43, 0, 127);
        4: set_layer(1, 44, 100, 100);
        5: set_layer(0, 0, 0, 60);
        6: set_layer(1, 40, 127, 100);
        7: set_layer(1, $urandom_range(30, 50), $urandom_range(0, 127),
                     $urandom_range(0, 127));
        8: set_layer($urandom_range(0, 1), $urandom_range(0, 127),
                     $urandom_range(0, 127), $urandom_range(0, 127));
        default: set_layer(0, 36, 1, 127);
      endcase
      @(negedge clk_i);
      if (phase == 9) idle_on = 1'b0;
      for (int n = 0; n < 100; n++) stimulus_words.push_back(random_word());
      if (phase == 2) hold_go = 1'b1;
      wait_until_quiet();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/dss_pkg.sv
hw/rtl/dss_velocity.sv
hw/rtl/drum_step_sequencer_ratchet.sv
hw/rtl/dss_checker.sv
sim/drum_step_sequencer_ratchet_tb.sv
